>>> rtl/gdfw_pkg.sv
package gdfw_pkg;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_WALK  = 2'd1,
      ACT_CLRM  = 2'd2,
      ACT_CLRG  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_VISIT   = 3'd0,
      ST_ADDED   = 3'd1,
      ST_SEEN    = 3'd2,
      ST_BAD     = 3'd3,
      ST_FULL    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_A,
      S_ADD_B,
      S_WALK_HEAD,
      S_WALK_TOP,
      S_WALK_NODE,
      S_WALK_TGT,
      S_WALK_PUSH,
      S_OUT
   } state_type;

   localparam int LINK_W = 10;
   localparam logic [LINK_W-1:0] NULL_LINK = 10'd1023;
   localparam logic [6:0] CSR_VCOUNT_RESET = 7'd64;

endpackage

>>> rtl/graph_depth_first_walk.sv
// a status-only word answers from idle once accepted; an add edge writes node a->b, reads
// the head of b, writes node b->a, then reports; a walk pushes the start list, then pops
// exhausted lists, skips marked targets, pushes each new target's list and ends on an empty
// stack; each visit leaves once the next step is known; one word in flight at a time
// reset: synchronous active high; clears head valid bits, marks, fill count, stack pointer
// vertex_count resets to 64; edge memory and walk stack hold no reset
module graph_depth_first_walk #(
   parameter int MAX_VERTICES   = 64,
   parameter int MAX_EDGE_NODES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_first_vertex,
   input  logic [5:0]  req_second_vertex,
   input  logic        req_valid,
   output logic        req_ready,
   output logic [5:0]  rsp_vertex,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gdfw_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGE_NODES);
   localparam int UW = $clog2(MAX_EDGE_NODES + 1);

   // memories: list heads, edge nodes (target and link), walk stack
   logic [LINK_W-1:0] head_mem [MAX_VERTICES];
   logic [5:0]        tgt_mem  [MAX_EDGE_NODES];
   logic [LINK_W-1:0] lnk_mem  [MAX_EDGE_NODES];
   logic [LINK_W-1:0] stk_mem  [MAX_VERTICES];

   // valid bits give head memory its empty reset value
   logic [MAX_VERTICES-1:0] head_ok_ff, head_ok_in;
   logic [MAX_VERTICES-1:0] mark_ff, mark_in;

   state_type state_ff, state_in;
   logic [6:0]     vcount_ff;
   logic [UW-1:0]  used_ff, used_in;
   logic [VW:0]    sp_ff, sp_in;
   logic [1:0]     act_ff, act_in;
   logic [5:0]     a_ff, a_in, b_ff, b_in;
   logic [LINK_W-1:0] p_ff, p_in;
   logic           busy_ff, busy_in;     // result still follows for this word

   // output register
   logic       ovalid_ff, ovalid_in;
   logic [5:0] ovx_ff, ovx_in;
   logic [2:0] ost_ff, ost_in;
   logic       olast_ff, olast_in;

   // a visit waits here until the walk knows whether it is the last one
   logic       pend_ff, pend_in;
   logic [5:0] pvx_ff, pvx_in;
   logic       vis_go;
   logic [5:0] vis_vx;

   // memory ports
   logic          h_we, h_re;
   logic [VW-1:0] h_wa, h_ra;
   logic [LINK_W-1:0] h_wd, h_rd_ff;
   logic          h_rok_ff;
   logic          e_we;
   logic [EW-1:0] e_a;
   logic [5:0]    e_wt, e_rt_ff;
   logic [LINK_W-1:0] e_wl, e_rl_ff;
   logic          s_we;
   logic [VW-1:0] s_wa, s_ra;
   logic [LINK_W-1:0] s_wd, s_rd_ff;

   logic [6:0] cnt;
   logic       acc;
   logic       a_bad, b_bad, no_room;

   always_comb begin
      if (vcount_ff == 7'd0) cnt = 7'd1;
      else if (vcount_ff > 7'(MAX_VERTICES)) cnt = 7'(MAX_VERTICES);
      else cnt = vcount_ff;
   end

   assign a_bad   = {1'b0, a_ff} >= cnt;
   assign b_bad   = {1'b0, b_ff} >= cnt;
   assign no_room = 32'(used_ff) + 2 > MAX_EDGE_NODES;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {25'd0, vcount_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CSR_VCOUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         vcount_ff <= csr_pwdata[6:0];
      end
   end

   // synchronous memories
   always_ff @(posedge clock) begin
      if (h_we) head_mem[h_wa] <= h_wd;
      if (h_re) begin
         h_rd_ff  <= head_mem[h_ra];
         h_rok_ff <= head_ok_ff[h_ra] && !(h_we && h_wa == h_ra);
      end
      if (e_we) begin
         tgt_mem[e_a] <= e_wt;
         lnk_mem[e_a] <= e_wl;
      end
      e_rt_ff <= tgt_mem[e_a];
      e_rl_ff <= lnk_mem[e_a];
      if (s_we) stk_mem[s_wa] <= s_wd;
      s_rd_ff <= stk_mem[s_ra];
   end

   logic [LINK_W-1:0] head_val;
   assign head_val = h_rok_ff ? h_rd_ff : NULL_LINK;

   assign req_ready = (state_ff == S_IDLE) && !busy_ff;
   assign acc       = req_valid && req_ready;

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (busy_ff && out_free) begin
               case (action_type'(act_ff))
                  ACT_ADD: begin
                     if (a_bad || b_bad || no_room) state_in = S_IDLE;
                     else state_in = S_ADD_RD;
                  end
                  ACT_WALK: begin
                     if (a_bad || mark_ff[a_ff[VW-1:0]]) state_in = S_IDLE;
                     else state_in = S_WALK_HEAD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_RD:    state_in = S_ADD_A;
         S_ADD_A:     state_in = S_ADD_B;
         S_ADD_B:     state_in = S_OUT;
         S_WALK_HEAD: state_in = S_WALK_TOP;
         S_WALK_TOP:  state_in = S_WALK_NODE;
         S_WALK_NODE: begin
            if (sp_ff == '0) state_in = S_OUT;
            else if (s_rd_ff == NULL_LINK || 32'(s_rd_ff) >= MAX_EDGE_NODES)
               state_in = S_WALK_TOP;
            else state_in = S_WALK_TGT;
         end
         S_WALK_TGT: begin
            if (32'(e_rt_ff) >= MAX_VERTICES || mark_ff[e_rt_ff[VW-1:0]])
               state_in = S_WALK_TOP;
            else if (out_free) state_in = S_WALK_PUSH;
         end
         S_WALK_PUSH: state_in = S_WALK_TOP;
         S_OUT:       if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in = used_ff; sp_in = sp_ff; act_in = act_ff; a_in = a_ff; b_in = b_ff;
      p_in = p_ff; busy_in = busy_ff;
      head_ok_in = head_ok_ff; mark_in = mark_ff;
      ovalid_in = ovalid_ff && !rsp_ready; ovx_in = ovx_ff; ost_in = ost_ff;
      olast_in = olast_ff;
      pend_in = pend_ff; pvx_in = pvx_ff; vis_go = 1'b0; vis_vx = '0;
      h_we = 1'b0; h_wa = a_ff[VW-1:0]; h_wd = '0; h_re = 1'b0; h_ra = a_ff[VW-1:0];
      e_we = 1'b0; e_a = used_ff[EW-1:0]; e_wt = b_ff; e_wl = head_val;
      s_we = 1'b0; s_wa = '0; s_wd = head_val; s_ra = '0;
      if (sp_ff != '0) s_ra = VW'(sp_ff - 1'b1);
      if (acc) begin
         act_in = req_action; a_in = req_first_vertex; b_in = req_second_vertex;
         busy_in = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (busy_ff && out_free) begin
               ovx_in = '0; olast_in = 1'b1;
               case (action_type'(act_ff))
                  ACT_ADD: begin
                     if (a_bad || b_bad) begin
                        ovalid_in = 1'b1; ost_in = ST_BAD; busy_in = 1'b0;
                     end else if (no_room) begin
                        ovalid_in = 1'b1; ost_in = ST_FULL; busy_in = 1'b0;
                     end else begin
                        h_re = 1'b1; h_ra = a_ff[VW-1:0];
                     end
                  end
                  ACT_WALK: begin
                     if (a_bad) begin
                        ovalid_in = 1'b1; ost_in = ST_BAD; busy_in = 1'b0;
                     end else if (mark_ff[a_ff[VW-1:0]]) begin
                        ovalid_in = 1'b1; ost_in = ST_SEEN; busy_in = 1'b0;
                     end else begin
                        mark_in[a_ff[VW-1:0]] = 1'b1;
                        vis_go = 1'b1; vis_vx = a_ff;
                        h_re = 1'b1; h_ra = a_ff[VW-1:0];
                     end
                  end
                  ACT_CLRM: begin
                     mark_in = '0; ovalid_in = 1'b1; ost_in = ST_CLEARED; busy_in = 1'b0;
                  end
                  default: begin
                     head_ok_in = '0; used_in = '0;
                     ovalid_in = 1'b1; ost_in = ST_CLEARED; busy_in = 1'b0;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            // node a->b, then read head of b (after a's head is rewritten)
            e_we = 1'b1; e_a = used_ff[EW-1:0]; e_wt = b_ff; e_wl = head_val;
            h_we = 1'b1; h_wa = a_ff[VW-1:0]; h_wd = LINK_W'(used_ff);
            head_ok_in[a_ff[VW-1:0]] = 1'b1;
            used_in = used_ff + 1'b1;
         end
         S_ADD_A: begin
            h_re = 1'b1; h_ra = b_ff[VW-1:0];
         end
         S_ADD_B: begin
            e_we = 1'b1; e_a = used_ff[EW-1:0]; e_wt = a_ff; e_wl = head_val;
            h_we = 1'b1; h_wa = b_ff[VW-1:0]; h_wd = LINK_W'(used_ff);
            head_ok_in[b_ff[VW-1:0]] = 1'b1;
            used_in = used_ff + 1'b1;
         end
         S_WALK_HEAD: begin
            s_we = 1'b1; s_wa = '0; s_wd = head_val; sp_in = (VW+1)'(1);
         end
         S_WALK_TOP: begin
            // stack read issued by s_ra; result in s_rd_ff next cycle
         end
         S_WALK_NODE: begin
            p_in = s_rd_ff;
            if (sp_ff != '0) begin
               if (s_rd_ff == NULL_LINK || 32'(s_rd_ff) >= MAX_EDGE_NODES) begin
                  sp_in = sp_ff - 1'b1;
               end else begin
                  e_a = s_rd_ff[EW-1:0];
               end
            end
         end
         S_WALK_TGT: begin
            // keep reading the same node while the output is held
            e_a = p_ff[EW-1:0];
            if (!(32'(e_rt_ff) >= MAX_VERTICES || mark_ff[e_rt_ff[VW-1:0]])) begin
               if (out_free) begin
                  s_we = 1'b1; s_wa = VW'(sp_ff - 1'b1); s_wd = e_rl_ff;
                  mark_in[e_rt_ff[VW-1:0]] = 1'b1;
                  vis_go = 1'b1; vis_vx = e_rt_ff;
                  h_re = 1'b1; h_ra = e_rt_ff[VW-1:0];
               end
            end else begin
               s_we = 1'b1; s_wa = VW'(sp_ff - 1'b1); s_wd = e_rl_ff;
            end
         end
         S_WALK_PUSH: begin
            if (32'(sp_ff) < MAX_VERTICES) begin
               s_we = 1'b1; s_wa = VW'(sp_ff); s_wd = head_val; sp_in = sp_ff + 1'b1;
            end
         end
         S_OUT: begin
            // add edge reports here; a walk sends its held visit flagged as last
            if (out_free) begin
               busy_in = 1'b0;
               ovalid_in = 1'b1; ovx_in = '0; ost_in = ST_ADDED; olast_in = 1'b1;
               if (act_ff != ACT_ADD) begin
                  ovx_in = pvx_ff; ost_in = ST_VISIT; pend_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      // a new visit pushes the held one out, which then cannot be the last
      if (vis_go) begin
         if (pend_ff) begin
            ovalid_in = 1'b1; ovx_in = pvx_ff; ost_in = ST_VISIT; olast_in = 1'b0;
         end
         pend_in = 1'b1; pvx_in = vis_vx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; busy_ff <= 1'b0; used_ff <= '0; sp_ff <= '0;
         head_ok_ff <= '0; mark_ff <= '0; ovalid_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; busy_ff <= busy_in; used_ff <= used_in; sp_ff <= sp_in;
         head_ok_ff <= head_ok_in; mark_ff <= mark_in; ovalid_ff <= ovalid_in;
         pend_ff <= pend_in;
      end
      act_ff <= act_in; a_ff <= a_in; b_ff <= b_in; p_ff <= p_in;
      ovx_ff <= ovx_in; ost_ff <= ost_in; olast_ff <= olast_in;
      pvx_ff <= pvx_in;
   end

   assign rsp_valid  = ovalid_ff;
   assign rsp_vertex = ovx_ff;
   assign rsp_status = ost_ff;
   assign rsp_last   = olast_ff;

   // stack pointer never exceeds its depth
   assert property (@(posedge clock) disable iff (reset) 32'(sp_ff) <= MAX_VERTICES)
      else $error("stack overflow");
   // fill count stays within the store
   assert property (@(posedge clock) disable iff (reset) 32'(used_ff) <= MAX_EDGE_NODES)
      else $error("edge store overrun");
   // no new word accepted while a result is still owed
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !req_ready)
      else $error("accept while busy");
   // add edge writes both nodes with the read of b's head between them
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD_RD |=> ##1 state_ff == S_ADD_B)
      else $error("add sequence broken");

endmodule
